>>> sv/ring_fifo_overflow_policy_top_macros.svh
// Assertion helpers for the ring FIFO block. Each macro expects clk and rst_n
// in the scope where it is used.
`ifndef RING_FIFO_OVERFLOW_POLICY_TOP_MACROS_SVH
`define RING_FIFO_OVERFLOW_POLICY_TOP_MACROS_SVH

// same-cycle implication
`define RFOP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RFOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/rfop_pkg.sv
// ----------------------------------------------------------------------------
// rfop_pkg
// Shared constants, codes and types for the ring FIFO with overflow policy.
// ----------------------------------------------------------------------------
`default_nettype none

package rfop_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int PTR_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int WORD_W    = 32;
  localparam int DEPTH_W   = 9;
  localparam int MODE_W    = 2;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 3;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  localparam logic [CMD_W-1:0] CMD_ADMIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [MODE_W-1:0] MODE_BACKPRESSURE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DROP_OLDEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DROP_NEWEST  = 2'd2;

  localparam logic [STAT_W-1:0] ST_QUEUED       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BACKPRESSURE = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED      = 3'd2;
  localparam logic [STAT_W-1:0] ST_REPLACED     = 3'd3;
  localparam logic [STAT_W-1:0] ST_POPPED       = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY        = 3'd5;
  localparam logic [STAT_W-1:0] ST_INVALID      = 3'd6;
  localparam logic [STAT_W-1:0] ST_CLEARED      = 3'd7;

  // register word index (paddr[2])
  localparam logic REG_DEPTH = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [MODE_W-1:0]  mode;
    logic               flush;
  } cfg_t;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] depth);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= depth) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/rfop_in_if.sv
// ----------------------------------------------------------------------------
// rfop_in_if
// Command channel: one transaction carries a command and a word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfop_in_if;
  logic                         valid;
  logic                         ready;
  logic [rfop_pkg::CMD_W-1:0]   command;
  logic [rfop_pkg::WORD_W-1:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

>>> sv/rfop_out_if.sv
// ----------------------------------------------------------------------------
// rfop_out_if
// Result channel: status, returned word and occupancy per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfop_out_if;
  logic                         valid;
  logic                         ready;
  logic [rfop_pkg::STAT_W-1:0]  status;
  logic [rfop_pkg::WORD_W-1:0]  out_value;
  logic [rfop_pkg::CNT_W-1:0]   occupancy;

  modport source (output valid, output status, output out_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input out_value, input occupancy,
                  output ready);
endinterface

`default_nettype wire

>>> sv/ring_fifo_overflow_policy_top.sv
// ----------------------------------------------------------------------------
// ring_fifo_overflow_policy_top
// Circular FIFO of 32-bit words with configurable depth and overflow policy.
// Each command transaction (admit, pop, clear) yields one result transaction
// carrying a status, a word and the occupancy after the step. One transaction
// is taken per cycle while the result side keeps up; its result is offered in
// the following cycle from the result register, the returned word coming from
// a registered read of the slot memory (one read and one write port).
// Writing the depth register empties the queue; the slot store is never
// cleared and needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_overflow_policy_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rfop_in_if.sink                            in_ch,
  rfop_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rfop_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [rfop_pkg::CFG_DW-1:0]   pwdata,
  output logic      [rfop_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready
);

  rfop_pkg::cfg_t cfg;

  rfop_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfop_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

>>> sv/rfop_cfg.sv
// ----------------------------------------------------------------------------
// rfop_cfg
// APB register file: depth in use and overflow mode. A depth write flushes.
// ----------------------------------------------------------------------------
`default_nettype none

module rfop_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rfop_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [rfop_pkg::CFG_DW-1:0]   pwdata,
  output logic      [rfop_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready,
  output rfop_pkg::cfg_t                     cfg
);

  logic [rfop_pkg::DEPTH_W-1:0] depth_r;
  logic [rfop_pkg::MODE_W-1:0]  mode_r;
  logic                         wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= rfop_pkg::DEPTH_W'(rfop_pkg::MAX_SLOTS);
      mode_r  <= rfop_pkg::MODE_BACKPRESSURE;
    end else if (wr) begin
      if (paddr[2] == rfop_pkg::REG_DEPTH) begin
        depth_r <= pwdata[rfop_pkg::DEPTH_W-1:0];
      end else begin
        mode_r <= pwdata[rfop_pkg::MODE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rfop_pkg::REG_DEPTH) begin
      prdata = rfop_pkg::CFG_DW'(depth_r);
    end else begin
      prdata = rfop_pkg::CFG_DW'(mode_r);
    end
  end

  assign cfg.depth = depth_r;
  assign cfg.mode  = mode_r;
  assign cfg.flush = wr && (paddr[2] == rfop_pkg::REG_DEPTH);

endmodule

`default_nettype wire

>>> sv/rfop_core.sv
// ----------------------------------------------------------------------------
// rfop_core
// Pointer/count update, slot memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfop_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rfop_pkg::cfg_t  cfg,
  rfop_in_if.sink              in_ch,
  rfop_out_if.source           out_ch
);

`include "ring_fifo_overflow_policy_top_macros.svh"

  localparam int PW = rfop_pkg::PTR_W;
  localparam int CW = rfop_pkg::CNT_W;
  localparam int WW = rfop_pkg::WORD_W;

  logic [WW-1:0] mem [rfop_pkg::MAX_SLOTS];

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] depth_eff;

  logic                        out_valid_r;
  logic [rfop_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [WW-1:0]               word_r, word_nxt;
  logic                        use_mem_r, use_mem_nxt;
  logic [CW-1:0]               occ_r;
  logic [WW-1:0]               rd_r;
  logic                        we;
  logic                        acc;

  always_comb begin
    if (cfg.depth == '0) begin
      depth_eff = CW'(1);
    end else if (rfop_pkg::DEPTH_W'(cfg.depth) > rfop_pkg::DEPTH_W'(rfop_pkg::MAX_SLOTS)) begin
      depth_eff = CW'(rfop_pkg::MAX_SLOTS);
    end else begin
      depth_eff = CW'(cfg.depth);
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    status_nxt  = rfop_pkg::ST_INVALID;
    word_nxt    = rfop_pkg::ALL_ONES;
    use_mem_nxt = 1'b0;
    we          = 1'b0;
    case (in_ch.command)
      rfop_pkg::CMD_ADMIT: begin
        if (in_ch.value == rfop_pkg::ALL_ONES ||
            (cfg.mode != rfop_pkg::MODE_BACKPRESSURE &&
             cfg.mode != rfop_pkg::MODE_DROP_OLDEST &&
             cfg.mode != rfop_pkg::MODE_DROP_NEWEST)) begin
          status_nxt = rfop_pkg::ST_INVALID;
        end else if (count_r < depth_eff) begin
          we         = 1'b1;
          tail_nxt   = rfop_pkg::advance(tail_r, depth_eff);
          count_nxt  = count_r + CW'(1);
          status_nxt = rfop_pkg::ST_QUEUED;
        end else if (cfg.mode == rfop_pkg::MODE_BACKPRESSURE) begin
          status_nxt = rfop_pkg::ST_BACKPRESSURE;
        end else if (cfg.mode == rfop_pkg::MODE_DROP_NEWEST) begin
          word_nxt   = in_ch.value;
          status_nxt = rfop_pkg::ST_DROPPED;
        end else begin
          use_mem_nxt = 1'b1;
          we          = 1'b1;
          head_nxt    = rfop_pkg::advance(head_r, depth_eff);
          tail_nxt    = rfop_pkg::advance(tail_r, depth_eff);
          status_nxt  = rfop_pkg::ST_REPLACED;
        end
      end
      rfop_pkg::CMD_POP: begin
        if (count_r == '0) begin
          status_nxt = rfop_pkg::ST_EMPTY;
        end else begin
          use_mem_nxt = 1'b1;
          head_nxt    = rfop_pkg::advance(head_r, depth_eff);
          count_nxt   = count_r - CW'(1);
          status_nxt  = rfop_pkg::ST_POPPED;
        end
      end
      rfop_pkg::CMD_CLEAR: begin
        head_nxt   = '0;
        tail_nxt   = '0;
        count_nxt  = '0;
        status_nxt = rfop_pkg::ST_CLEARED;
      end
      default: begin
        status_nxt = rfop_pkg::ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg.flush) begin
        head_r  <= '0;
        tail_r  <= '0;
        count_r <= '0;
      end else if (acc) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r  <= status_nxt;
      word_r    <= word_nxt;
      use_mem_r <= use_mem_nxt;
      occ_r     <= count_nxt;
    end
  end

  // read-before-write: eviction on a full queue reads the slot it overwrites
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= mem[head_r];
    end
    if (acc && we) begin
      mem[tail_r] <= in_ch.value;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_value = use_mem_r ? rd_r : word_r;
  assign out_ch.occupancy = occ_r;

  `RFOP_ASSERT_NOW(a_count_le_depth, 1'b1, count_r <= depth_eff,
                   "entry count exceeds depth in use")
  `RFOP_ASSERT_NOW(a_empty_ptrs, count_r == '0, head_r == tail_r,
                   "empty queue with head and tail apart")
  `RFOP_ASSERT_NEXT(a_pop_dec, acc && !cfg.flush && in_ch.command == rfop_pkg::CMD_POP &&
                    count_r != '0, count_r == $past(count_r) - CW'(1),
                    "pop did not decrement the count")
  `RFOP_ASSERT_NOW(a_clear_occ, out_valid_r && status_r == rfop_pkg::ST_CLEARED,
                   occ_r == '0, "cleared transaction reports nonzero occupancy")

endmodule

`default_nettype wire
